### hdl/race_timer_gate_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Race timer gate controller - assertion macros
// Short forms for concurrent assertions with active-low reset, by default on clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef RACE_TIMER_GATE_CONTROLLER_CORE_MACROS_SVH
`define RACE_TIMER_GATE_CONTROLLER_CORE_MACROS_SVH

// assertion with explicit clock and active-low reset
`define RTGC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: lbl");

// assertion on the block clock and reset
`define RTGC_ASSERT(lbl, prop) \
  `RTGC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### hdl/rtgc_pkg.sv
// ----------------------------------------------------------------------------
// Race timer gate controller - package
// Payload types, codes, configuration defaults and the display helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rtgc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] BlindWindowRst = 16'd1000;
  localparam logic [11:0] HsIntervalRst = 12'd300;
  localparam logic [3:0] HsRetriesRst = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLIND_WINDOW = 2'd0,
    CFG_HS_INTERVAL  = 2'd1,
    CFG_HS_RETRIES   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PASS = 2'd1,
    OP_RX   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_SHORT = 2'd1,
    KEY_LONG  = 2'd2
  } key_e;

  typedef enum logic [2:0] {
    RX_UNKNOWN = 3'd0,
    RX_STAR    = 3'd1,
    RX_STOP    = 3'd2,
    RX_RSET    = 3'd3,
    RX_PING    = 3'd4
  } rx_e;

  typedef enum logic [2:0] {
    TX_NONE = 3'd0,
    TX_PING = 3'd1,
    TX_STAR = 3'd2,
    TX_STOP = 3'd3,
    TX_RSET = 3'd4
  } tx_e;

  typedef enum logic [1:0] {
    MODE_HS    = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DISP_CONN    = 2'd0,
    DISP_WAIT    = 2'd1,
    DISP_READY   = 2'd2,
    DISP_ELAPSED = 2'd3
  } disp_e;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] key_event;
    logic       light_hit;
    logic       ping_acked;
    logic [2:0] rx_command;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  tx_command;
    logic [1:0]  mode;
    logic [1:0]  display_choice;
    logic        wait_flash;
    logic [31:0] elapsed_ticks;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] blind_window;
    logic [11:0] hs_interval;
    logic [3:0]  hs_retries;
  } cfg_t;

  function automatic disp_e disp_of(mode_e mode, logic [3:0] retry, logic [3:0] retries);
    disp_e d;
    unique case (mode)
      MODE_HS:   d = (retry < retries) ? DISP_CONN : DISP_WAIT;
      MODE_IDLE: d = DISP_READY;
      default:   d = DISP_ELAPSED;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### hdl/rtgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Race timer gate controller - configuration registers
// Blind window, handshake interval and retry limit behind a write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rtgc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rtgc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output rtgc_pkg::cfg_t                    cfg_o
);

  rtgc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtgc_pkg::CFG_BLIND_WINDOW: cfg_d.blind_window = cfg_wdata_i;
        rtgc_pkg::CFG_HS_INTERVAL:  cfg_d.hs_interval = cfg_wdata_i[11:0];
        rtgc_pkg::CFG_HS_RETRIES:   cfg_d.hs_retries = cfg_wdata_i[3:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blind_window <= rtgc_pkg::BlindWindowRst;
      cfg_q.hs_interval  <= rtgc_pkg::HsIntervalRst;
      cfg_q.hs_retries   <= rtgc_pkg::HsRetriesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/rtgc_engine.sv
// ----------------------------------------------------------------------------
// Race timer gate controller - mode engine
// Holds mode and counters; works one request per fire and forms its results.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire rtgc_pkg::in_item_t  item_i,
  input  wire rtgc_pkg::cfg_t      cfg_i,
  output rtgc_pkg::out_item_t      res0_o,
  output rtgc_pkg::out_item_t      res1_o,
  output logic [1:0]               n_res_o
);

  rtgc_pkg::mode_e mode_q, mode_d;
  logic [31:0]     elapsed_q, elapsed_d;
  logic [11:0]     pass_q, pass_d;
  logic [3:0]      retry_q, retry_d;

  rtgc_pkg::out_item_t res_v [2];
  logic [1:0]          n_v;

  function automatic rtgc_pkg::out_item_t mk_res(rtgc_pkg::tx_e tx, rtgc_pkg::mode_e mode,
                                                 logic [3:0] retry, logic [3:0] retries,
                                                 logic flash, logic [31:0] elapsed);
    rtgc_pkg::out_item_t r;
    r.tx_command     = tx;
    r.mode           = mode;
    r.display_choice = rtgc_pkg::disp_of(mode, retry, retries);
    r.wait_flash     = flash;
    r.elapsed_ticks  = elapsed;
    r.last           = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [31:0] bw_ext;
    bw_ext    = {16'd0, cfg_i.blind_window};
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    pass_d    = pass_q;
    retry_d   = retry_q;
    n_v       = 2'd0;
    res_v[0]  = '0;
    res_v[1]  = '0;

    unique case (item_i.op)
      rtgc_pkg::OP_TICK: begin
        if (mode_q == rtgc_pkg::MODE_RUN) elapsed_d = elapsed_q + 32'd1;
      end
      rtgc_pkg::OP_PASS: begin
        if (mode_q == rtgc_pkg::MODE_HS) begin
          if (pass_q >= cfg_i.hs_interval) begin
            pass_d = '0;
            if (retry_q < cfg_i.hs_retries) begin
              if (item_i.ping_acked) mode_d = rtgc_pkg::MODE_IDLE;
              retry_d = retry_q + 4'd1;
              res_v[0] = mk_res(rtgc_pkg::TX_PING, mode_d, retry_d, cfg_i.hs_retries,
                                1'b0, elapsed_d);
              n_v = 2'd1;
            end else begin
              mode_d = rtgc_pkg::MODE_IDLE;  // out of attempts
            end
          end else begin
            pass_d = pass_q + 12'd1;
          end
        end else begin
          // sensor stop first, then the key acts on the mode it leaves
          if (mode_q == rtgc_pkg::MODE_RUN && item_i.light_hit && elapsed_q > bw_ext) begin
            mode_d = rtgc_pkg::MODE_PAUSE;
            res_v[0] = mk_res(rtgc_pkg::TX_STOP, mode_d, retry_d, cfg_i.hs_retries,
                              1'b0, elapsed_d);
            n_v = 2'd1;
          end
          if (mode_d == rtgc_pkg::MODE_IDLE || mode_d == rtgc_pkg::MODE_PAUSE) begin
            if (item_i.key_event == rtgc_pkg::KEY_SHORT) begin
              elapsed_d = '0;
              mode_d = rtgc_pkg::MODE_RUN;
              res_v[n_v[0]] = mk_res(rtgc_pkg::TX_STAR, mode_d, retry_d, cfg_i.hs_retries,
                                     1'b0, elapsed_d);
              n_v = n_v + 2'd1;
            end else if (item_i.key_event == rtgc_pkg::KEY_LONG) begin
              elapsed_d = '0;
              mode_d = rtgc_pkg::MODE_IDLE;
              res_v[n_v[0]] = mk_res(rtgc_pkg::TX_RSET, mode_d, retry_d, cfg_i.hs_retries,
                                     1'b0, elapsed_d);
              n_v = n_v + 2'd1;
            end
          end else if (mode_d == rtgc_pkg::MODE_RUN) begin
            if (item_i.key_event == rtgc_pkg::KEY_SHORT) begin
              if (elapsed_d < bw_ext) begin
                res_v[n_v[0]] = mk_res(rtgc_pkg::TX_NONE, mode_d, retry_d, cfg_i.hs_retries,
                                       1'b1, elapsed_d);
              end else begin
                mode_d = rtgc_pkg::MODE_PAUSE;
                res_v[n_v[0]] = mk_res(rtgc_pkg::TX_STOP, mode_d, retry_d, cfg_i.hs_retries,
                                       1'b0, elapsed_d);
              end
              n_v = n_v + 2'd1;
            end else if (item_i.key_event == rtgc_pkg::KEY_LONG) begin
              elapsed_d = '0;
              mode_d = rtgc_pkg::MODE_IDLE;
              res_v[n_v[0]] = mk_res(rtgc_pkg::TX_RSET, mode_d, retry_d, cfg_i.hs_retries,
                                     1'b0, elapsed_d);
              n_v = n_v + 2'd1;
            end
          end
        end
      end
      rtgc_pkg::OP_RX: begin
        unique case (item_i.rx_command)
          rtgc_pkg::RX_STAR: begin
            if (mode_q == rtgc_pkg::MODE_IDLE || mode_q == rtgc_pkg::MODE_PAUSE) begin
              elapsed_d = '0;
              mode_d = rtgc_pkg::MODE_RUN;
            end
          end
          rtgc_pkg::RX_STOP: begin
            if (mode_q == rtgc_pkg::MODE_RUN && elapsed_q > bw_ext)
              mode_d = rtgc_pkg::MODE_PAUSE;
          end
          rtgc_pkg::RX_RSET: begin
            elapsed_d = '0;
            mode_d = rtgc_pkg::MODE_IDLE;
          end
          rtgc_pkg::RX_PING: begin
            if (mode_q == rtgc_pkg::MODE_HS) mode_d = rtgc_pkg::MODE_IDLE;
          end
          default: ;  // unknown command
        endcase
      end
      default: ;  // unused op
    endcase

    // status result when nothing was sent
    if (n_v == 2'd0) begin
      res_v[0] = mk_res(rtgc_pkg::TX_NONE, mode_d, retry_d, cfg_i.hs_retries,
                        1'b0, elapsed_d);
      n_v = 2'd1;
    end
    if (n_v == 2'd1) res_v[0].last = 1'b1;
    else             res_v[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= rtgc_pkg::MODE_HS;
      elapsed_q <= '0;
      pass_q    <= '0;
      retry_q   <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      pass_q    <= pass_d;
      retry_q   <= retry_d;
    end
  end

  assign res0_o  = res_v[0];
  assign res1_o  = res_v[1];
  assign n_res_o = n_v;

endmodule

`default_nettype wire

### hdl/rtgc_result_buf.sv
// ----------------------------------------------------------------------------
// Race timer gate controller - result buffer
// Holds the one or two results of a request and drains them in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "race_timer_gate_controller_core_macros.svh"

module rtgc_result_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire rtgc_pkg::out_item_t res0_i,
  input  wire rtgc_pkg::out_item_t res1_i,
  input  wire logic [1:0]          n_res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rtgc_pkg::out_item_t      out_item_o
);

  rtgc_pkg::out_item_t slot0_q, slot1_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                head_q, head_d;
  logic                pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // room for a new pair once the last held result leaves
  assign free_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign out_item_o  = head_q ? slot1_q : slot0_q;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = n_res_i;
      head_d = 1'b0;
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res0_i;
      slot1_q <= res1_i;
    end
  end

  `RTGC_ASSERT(a_cnt_range, cnt_q != 2'd3)
  `RTGC_ASSERT(a_second_follows, (cnt_q == 2'd2 && out_ready_i) |=> (cnt_q == 2'd1 && head_q))
  `RTGC_ASSERT(a_first_of_pair, (out_valid_o && !out_item_o.last) |-> (cnt_q == 2'd2 && !head_q))
  `RTGC_ASSERT(a_load_fits, load_i |-> (free_o && n_res_i != 2'd0 && n_res_i != 2'd3))

endmodule

`default_nettype wire

### hdl/race_timer_gate_controller_core.sv
// ----------------------------------------------------------------------------
// Race timer gate controller - top level
// Finish-gate mode control for a race stopwatch with a valid/ready front end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries ticks, main-loop
//   passes and received radio commands. Output channel (out_valid_o/
//   out_ready_i/out_item_o) returns one or two results per request; the
//   final one has last set.
//   A request is registered on accept and worked once the result buffer has
//   room; its results are registered in the result buffer before they show.
//   Throughput is one request per cycle while each yields one result and is
//   taken at once; two results hold the output buffer until both are taken.
//   The input register takes one more request while a result waits to be
//   taken.
//   Reset puts the block in handshake mode with all counters cleared and the
//   registers at blind window 1000, interval 300, retries 5.
//   When the receiver stalls, the held result stays on the port, the queued
//   request waits in the input register and in_ready_o drops.
//   The user must write registers through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module race_timer_gate_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rtgc_pkg::in_item_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rtgc_pkg::out_item_t                out_item_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rtgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rtgc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  rtgc_pkg::in_item_t  in_q;
  logic                in_vld_q;
  rtgc_pkg::cfg_t      cfg;
  rtgc_pkg::out_item_t res0, res1;
  logic [1:0]          n_res;
  logic                buf_free;
  logic                fire;

  assign fire       = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
  end

  rtgc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  rtgc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res0_o (res0),
    .res1_o (res1),
    .n_res_o(n_res)
  );

  rtgc_result_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .res0_i     (res0),
    .res1_i     (res1),
    .n_res_i    (n_res),
    .free_o     (buf_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
